/* sv/dpm_pkg.sv */
package dpm_pkg;

	localparam int LEN_W = 10;
	localparam int CNT_OUT_W = 5;
	localparam logic [LEN_W-1:0] MSG_LEN_RESET = 10'd128;

	typedef enum logic [1:0] {
		EV_REQ_HIGH = 2'd0,
		EV_REQ_LOW  = 2'd1,
		EV_XFER     = 2'd2,
		EV_NONE     = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		STS_IGNORED     = 4'd0,
		STS_READ_START  = 4'd1,
		STS_WRITE_START = 4'd2,
		STS_EMPTY       = 4'd3,
		STS_FULL        = 4'd4,
		STS_EARLY_DROP  = 4'd5,
		STS_READ_DONE   = 4'd6,
		STS_READ_ABORT  = 4'd7,
		STS_WRITE_DONE  = 4'd8,
		STS_ZERO_DROP   = 4'd9
	} status_t;

	typedef struct packed {
		logic             port;
		logic [1:0]       event_kind;
		logic             mode_is_write;
		logic             request_level;
		logic             dma_finished;
		logic [LEN_W-1:0] dma_bytes_left;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           new_state;
		logic [3:0]           status;
		logic [LEN_W-1:0]     bytes_written;
		logic                 ack_application;
		logic                 ack_communication;
		logic                 indicate_application;
		logic                 indicate_communication;
		logic [CNT_OUT_W-1:0] count_to_communication;
		logic [CNT_OUT_W-1:0] count_to_application;
	} result_t;

	// classified event as handed from front to back
	typedef struct packed {
		logic             port;
		op_t              op;
		logic             mode_is_write;
		logic             request_level;
		logic [LEN_W-1:0] size;
	} cmd_t;

endpackage

/* sv/dpm_fifo.sv */
module dpm_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* sv/dpm_front.sv */
module dpm_front import dpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  in_item_t         item,
	output logic             full,
	input  logic             cfg_valid,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             cmd_pop,
	output cmd_t             cmd,
	output logic             cmd_empty
);

	logic [LEN_W-1:0] message_length_q;
	cmd_t             cmd_in;
	logic [LEN_W-1:0] remainder;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_length_q <= MSG_LEN_RESET;
		end else if (cfg_valid) begin
			message_length_q <= cfg_data;
		end
	end

	// size of a write that would end with this transaction
	assign remainder = (item.dma_bytes_left >= message_length_q) ? '0
		: message_length_q - item.dma_bytes_left;

	always_comb begin
		cmd_in.port          = item.port;
		cmd_in.mode_is_write = item.mode_is_write;
		cmd_in.request_level = item.request_level;
		cmd_in.size          = item.dma_finished ? message_length_q : remainder;
		case (item.event_kind)
			EV_REQ_HIGH: cmd_in.op = EV_REQ_HIGH;
			EV_REQ_LOW:  cmd_in.op = EV_REQ_LOW;
			EV_XFER:     cmd_in.op = EV_XFER;
			default:     cmd_in.op = EV_NONE;
		endcase
	end

	dpm_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

/* sv/dpm_back.sv */
module dpm_back import dpm_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_WRITE = 2'd2
	} pstate_t;

	pstate_t           port_state_q [2];
	logic [FILL_W-1:0] fill_q [2];
	logic [1:0]        ack_q;

	pstate_t           n_state [2];
	logic [FILL_W-1:0] n_fill [2];
	logic [1:0]        n_ack;
	status_t           status;
	logic [LEN_W-1:0]  bytes;
	logic              p;
	logic              inq;
	pstate_t           st;
	logic              fire;

	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign p        = cmd.port;
	assign inq      = ~cmd.port;
	assign st       = port_state_q[p];

	// the writing port feeds the queue of the same index, reads the other one
	always_comb begin
		n_state = port_state_q;
		n_fill  = fill_q;
		n_ack   = ack_q;
		status  = STS_IGNORED;
		bytes   = '0;
		case (cmd.op)
			EV_REQ_HIGH: begin
				if (st == ST_IDLE) begin
					if (cmd.mode_is_write) begin
						if (fill_q[p] == FILL_W'(QUEUE_DEPTH)) begin
							status = STS_FULL;
						end else if (!cmd.request_level) begin
							status = STS_EARLY_DROP;
						end else begin
							status     = STS_WRITE_START;
							n_state[p] = ST_WRITE;
							n_ack[p]   = 1'b1;
						end
					end else begin
						if (fill_q[inq] == '0) begin
							status = STS_EMPTY;
						end else if (!cmd.request_level) begin
							status = STS_EARLY_DROP;
						end else begin
							status     = STS_READ_START;
							n_state[p] = ST_READ;
							n_ack[p]   = 1'b1;
						end
					end
				end
			end
			EV_REQ_LOW: begin
				if (st == ST_READ) begin
					status     = STS_READ_ABORT;
					n_state[p] = ST_IDLE;
					n_ack[p]   = 1'b0;
				end else if (st == ST_WRITE) begin
					if (cmd.size == '0) begin
						status = STS_ZERO_DROP;
					end else begin
						status = STS_WRITE_DONE;
						bytes  = cmd.size;
						if (fill_q[p] != FILL_W'(QUEUE_DEPTH)) begin
							n_fill[p] = fill_q[p] + FILL_W'(1);
						end
					end
					n_state[p] = ST_IDLE;
					n_ack[p]   = 1'b0;
				end
			end
			EV_XFER: begin
				if (st == ST_READ) begin
					status = STS_READ_DONE;
					if (fill_q[inq] != '0) begin
						n_fill[inq] = fill_q[inq] - FILL_W'(1);
					end
					n_state[p] = ST_IDLE;
					n_ack[p]   = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.new_state              = n_state[p];
		res.status                 = status;
		res.bytes_written          = bytes;
		res.ack_application        = n_ack[0];
		res.ack_communication      = n_ack[1];
		res.indicate_application   = (n_fill[1] != '0);
		res.indicate_communication = (n_fill[0] != '0);
		res.count_to_communication = CNT_OUT_W'(n_fill[0]);
		res.count_to_application   = CNT_OUT_W'(n_fill[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_state_q[0] <= ST_IDLE;
			port_state_q[1] <= ST_IDLE;
			fill_q[0]       <= '0;
			fill_q[1]       <= '0;
			ack_q           <= '0;
		end else if (fire) begin
			port_state_q <= n_state;
			fill_q       <= n_fill;
			ack_q        <= n_ack;
		end
	end

`ifndef NO_ASSERTIONS
	a_ack_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(ack_q[0] == (port_state_q[0] != ST_IDLE)) && (ack_q[1] == (port_state_q[1] != ST_IDLE)))
		else $error("ack line out of step with port state");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_W'(QUEUE_DEPTH)) && (fill_q[1] <= FILL_W'(QUEUE_DEPTH)))
		else $error("queue fill above depth");

	a_write_done_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (status == STS_WRITE_DONE) && !p && (fill_q[0] != FILL_W'(QUEUE_DEPTH))
		|=> fill_q[0] == $past(fill_q[0]) + FILL_W'(1))
		else $error("write done did not add a message");

	a_read_needs_message: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (status == STS_READ_START) |-> fill_q[inq] != '0)
		else $error("read started on an empty queue");
`endif

endmodule

/* sv/dual_port_mailbox_handshake_fsm.sv */
// path: a pushed transaction is held in the command queue register, is handled
// by the back end once the result queue has room, and is then on the result
// ports from the result queue register
// throughput: one event per cycle while the result queue is not full; the back
// end updates port state and queue fills for one command each cycle it is not stalled
// reset: asynchronous, clears both ports to idle, fills to zero, acks low,
// message length back to 128, and empties the command and result queues
module dual_port_mailbox_handshake_fsm import dpm_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  in_item_t         item,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	cmd_t    cmd;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res;

	assign cfg_ready = 1'b1;

	dpm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	dpm_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	dpm_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule
